FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file, mbe_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MBE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MBE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mbe_pkg.sv
`timescale 1ns / 1ps
// Package for the monochrome bitmap expander: config and queue types, codes.
// No dependencies.
package mbe_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 13;
  localparam int ROW_WIDTH_W   = 13;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG_PIXEL       = 3'd0,
    REG_BG_PIXEL       = 3'd1,
    REG_USE_BACKGROUND = 3'd2,
    REG_BIT7_LEFT      = 3'd3,
    REG_FIRST_BIT_OFS  = 3'd4,
    REG_ROW_WIDTH      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]             fg_pixel;
    logic [7:0]             bg_pixel;
    logic                   use_background;
    logic                   bit7_left;
    logic [2:0]             first_bit_offset;
    logic [ROW_WIDTH_W-1:0] row_width;
  } cfg_t;

  // One classified byte: where to start, how many pixels, whether it ends the row
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] start_pos;
    logic [3:0] count;
    logic       row_end;
  } job_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/mbe_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input bytes and output pixels.
// Depends on nothing.
interface mbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] glyph_bits;
  modport source (output valid, output glyph_bits, input ready);
  modport sink (input valid, input glyph_bits, output ready);
endinterface

interface mbe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_value;
  logic       write_enable;
  logic       row_end;
  logic       last;
  modport source (output valid, output pixel_value, output write_enable,
                  output row_end, output last, input ready);
  modport sink (input valid, input pixel_value, input write_enable,
                input row_end, input last, output ready);
endinterface

FILE: rtl/mbe_front.sv
`timescale 1ns / 1ps
// Front end: accepts bitmap bytes, tracks the row column, classifies each byte.
// Depends on mbe_pkg and mbe_in_if.
module mbe_front #(
  parameter int MAX_WIDTH = mbe_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  mbe_in_if.sink          in_ch,
  input  mbe_pkg::cfg_t   cfg,
  input  mbe_pkg::q_stat_t q_stat,
  output logic            push,
  output mbe_pkg::job_t   job
);
  import mbe_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int EW = (ROW_WIDTH_W > WW) ? ROW_WIDTH_W : WW;

  logic [CW-1:0] col_r, col_nxt;
  logic [EW-1:0] rw_ext;
  logic [WW-1:0] width;
  logic [WW-1:0] col_ext;
  logic [WW-1:0] remain;
  logic [2:0]    start_pos;
  logic [3:0]    avail;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  // Effective row width: zero acts as one, clamp to the maximum
  always_comb begin
    rw_ext = EW'(cfg.row_width);
    if (rw_ext == '0) begin
      width = WW'(1);
    end else if (rw_ext > EW'(MAX_WIDTH)) begin
      width = WW'(MAX_WIDTH);
    end else begin
      width = rw_ext[WW-1:0];
    end
  end

  // Classify the byte against the pixels left in the row
  always_comb begin
    col_ext   = {1'b0, col_r};
    start_pos = (col_r == '0) ? cfg.first_bit_offset : 3'd0;
    avail     = 4'd8 - {1'b0, start_pos};
    remain    = width - col_ext;
    job.data  = in_ch.glyph_bits;
    job.start_pos = start_pos;
    if (col_ext + WW'(1) >= width) begin
      // width already reached (or lowered below): next pixel ends the row
      job.count   = 4'd1;
      job.row_end = 1'b1;
      col_nxt     = '0;
    end else if (remain <= WW'(avail)) begin
      job.count   = remain[3:0];
      job.row_end = 1'b1;
      col_nxt     = '0;
    end else begin
      job.count   = avail;
      job.row_end = 1'b0;
      col_nxt     = col_r + CW'(avail);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
    end
  end

endmodule

FILE: rtl/mbe_queue.sv
`timescale 1ns / 1ps
// Two-entry job queue between the front and back ends.
// Depends on mbe_pkg.
module mbe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mbe_pkg::job_t    push_job,
  input  logic             pop,
  output mbe_pkg::job_t    head,
  output mbe_pkg::q_stat_t stat
);
  import mbe_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/mbe_back.sv
`timescale 1ns / 1ps
// Back end: walks the pixels of the head job and drives the output register.
// Depends on mbe_pkg and mbe_out_if.
module mbe_back (
  input  logic             clk,
  input  logic             rst_n,
  input  mbe_pkg::cfg_t    cfg,
  input  mbe_pkg::job_t    head,
  input  mbe_pkg::q_stat_t q_stat,
  output logic             pop,
  mbe_out_if.source        out_ch
);
  import mbe_pkg::*;

  logic [2:0] k_r;
  logic [2:0] pos;
  logic [2:0] sel;
  logic       bit_set;
  logic       we;
  logic       is_last;
  logic       emit;
  logic       out_valid_r;
  logic [7:0] pix_r;
  logic       we_r, row_end_r, last_r;

  // Pick the bit for the current pixel
  always_comb begin
    pos     = head.start_pos + k_r;
    sel     = cfg.bit7_left ? (3'd7 - pos) : pos;
    bit_set = head.data[sel];
    we      = bit_set || cfg.use_background;
    is_last = ({1'b0, k_r} + 4'd1) == head.count;
    emit    = !q_stat.empty && (!out_valid_r || out_ch.ready);
    pop     = emit && is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (emit) begin
      k_r <= is_last ? 3'd0 : k_r + 3'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_r     <= bit_set ? cfg.fg_pixel : (we ? cfg.bg_pixel : 8'd0);
      we_r      <= we;
      row_end_r <= is_last && head.row_end;
      last_r    <= is_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_value  = pix_r;
  assign out_ch.write_enable = we_r;
  assign out_ch.row_end      = row_end_r;
  assign out_ch.last         = last_r;

endmodule

FILE: rtl/mono_bitmap_to_8bpp_expander_top.sv
`timescale 1ns / 1ps
// Top level of the monochrome bitmap expander: config registers and wiring.
// Depends on mbe_pkg, mbe_if, mbe_front, mbe_queue, mbe_back.

// Each accepted bitmap byte yields one to eight pixel transactions, one per
// cycle while the receiver is ready; the back end's per-pixel sequencer sets
// that pace. The front end classifies bytes at one per cycle into a
// two-entry queue while the queue is not full, so input keeps flowing while
// pixels drain, and the output register decouples the downstream stall. A
// byte's first pixel passes through its queue entry and then the output
// register before it is presented on the output.
// Configuration may be written only while the block holds no pending work.
module mono_bitmap_to_8bpp_expander_top #(
  parameter int MAX_WIDTH = mbe_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  mbe_in_if.sink                             in_ch,
  mbe_out_if.source                          out_ch
);
  import mbe_pkg::*;

  cfg_t    cfg_r;
  job_t    push_job, head;
  q_stat_t q_stat;
  logic    push, pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_pixel         <= 8'd0;
      cfg_r.bg_pixel         <= 8'd0;
      cfg_r.use_background   <= 1'b0;
      cfg_r.bit7_left        <= 1'b1;
      cfg_r.first_bit_offset <= 3'd0;
      cfg_r.row_width        <= ROW_WIDTH_W'(1);
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FG_PIXEL:       cfg_r.fg_pixel         <= cfg_wdata[7:0];
        REG_BG_PIXEL:       cfg_r.bg_pixel         <= cfg_wdata[7:0];
        REG_USE_BACKGROUND: cfg_r.use_background   <= cfg_wdata[0];
        REG_BIT7_LEFT:      cfg_r.bit7_left        <= cfg_wdata[0];
        REG_FIRST_BIT_OFS:  cfg_r.first_bit_offset <= cfg_wdata[2:0];
        REG_ROW_WIDTH:      cfg_r.row_width        <= cfg_wdata[ROW_WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg_r),
    .q_stat(q_stat),
    .push  (push),
    .job   (push_job)
  );

  mbe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  mbe_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .head  (head),
    .q_stat(q_stat),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

FILE: rtl/mbe_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the bitmap expander, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module mbe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel_value,
  input logic       out_write_enable,
  input logic       out_row_end,
  input logic       out_last
);

  // A row end always closes the byte's pixel run
  `MBE_ASSERT_IMP(a_row_end_is_last, clk, rst_n, out_valid && out_row_end, out_last, "row_end without last")

  // Skipped pixels carry a zero value
  `MBE_ASSERT_IMP(a_skip_zero, clk, rst_n, out_valid && !out_write_enable, out_pixel_value == 8'd0, "skipped pixel nonzero")

  // A stalled transaction stays valid
  `MBE_ASSERT_NXT(a_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid, "valid dropped while stalled")

  // A stalled transaction keeps its payload
  `MBE_ASSERT_NXT(a_payload_holds, clk, rst_n, out_valid && !out_ready, $stable({out_pixel_value, out_write_enable, out_row_end, out_last}), "payload changed while stalled")

endmodule

bind mono_bitmap_to_8bpp_expander_top mbe_checker u_mbe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pixel_value (out_ch.pixel_value),
  .out_write_enable(out_ch.write_enable),
  .out_row_end     (out_ch.row_end),
  .out_last        (out_ch.last)
);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the monochrome bitmap expander: sends bitmap bytes, predicts
// the pixel stream with a local expansion model and checks every pixel.
// Depends on mbe_pkg, mbe_if and mono_bitmap_to_8bpp_expander_top.
module tb;
  import mbe_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_ITEMS   = 90;
  localparam int WIDE_ROW_BYTES = 24;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       write_enable;
    logic       row_end;
    logic       last;
  } pixel_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mbe_in_if  in_ch ();
  mbe_out_if out_ch ();

  mono_bitmap_to_8bpp_expander_top #(
    .MAX_WIDTH(MAX_WIDTH_DEF)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Expansion model: register copies and row position
  logic [7:0]             exp_fg     = 8'd0;
  logic [7:0]             exp_bg     = 8'd0;
  logic                   exp_use_bg = 1'b0;
  logic                   exp_msb    = 1'b1;
  logic [2:0]             exp_ofs    = 3'd0;
  logic [ROW_WIDTH_W-1:0] exp_width  = 13'd1;
  int unsigned            exp_col    = 0;

  pixel_t pending_pixels[$];

  int errors    = 0;
  int cycles    = 0;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_left = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Expand one accepted byte into the pixels it should produce
  function automatic void expand_byte(input logic [7:0] b);
    int unsigned w;
    int unsigned pos;
    logic        set;
    pixel_t      px;
    w = (exp_width == 0) ? 1 : exp_width;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    pos = (exp_col == 0) ? exp_ofs : 0;
    while (pos < 8) begin
      set = exp_msb ? b[7 - pos] : b[pos];
      px.write_enable = set | exp_use_bg;
      px.pixel_value  = set ? exp_fg : (px.write_enable ? exp_bg : 8'd0);
      px.row_end      = (exp_col + 1 >= w);
      px.last         = px.row_end || (pos == 7);
      pending_pixels.push_back(px);
      if (px.row_end) begin
        exp_col = 0;
        break;
      end
      exp_col++;
      pos++;
    end
  endfunction

  // Byte values with the all-zero and all-one cases weighted up
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Register write; cfg_we goes low again before the task returns, keeping write strobes apart
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FG_PIXEL:       exp_fg     = value[7:0];
      REG_BG_PIXEL:       exp_bg     = value[7:0];
      REG_USE_BACKGROUND: exp_use_bg = value[0];
      REG_BIT7_LEFT:      exp_msb    = value[0];
      REG_FIRST_BIT_OFS:  exp_ofs    = value[2:0];
      REG_ROW_WIDTH:      exp_width  = value[ROW_WIDTH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned fg, input int unsigned bg,
                           input int unsigned use_bg, input int unsigned msb,
                           input int unsigned ofs, input int unsigned width);
    write_reg(REG_FG_PIXEL, fg);
    write_reg(REG_BG_PIXEL, bg);
    write_reg(REG_USE_BACKGROUND, use_bg);
    write_reg(REG_BIT7_LEFT, msb);
    write_reg(REG_FIRST_BIT_OFS, ofs);
    write_reg(REG_ROW_WIDTH, width);
  endtask

  // One input transaction; valid stays high on return so back-to-back bytes flow
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.glyph_bits <= b;
    do @(posedge clk); while (!in_ch.ready);
    expand_byte(b);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_byte(pick_byte());
  endtask

  // Drop valid and wait until every predicted pixel has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reset values: one pixel per row, MSB first, no background
  task automatic test_reset_state();
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    settle();
  endtask

  // Full bytes in both bit orders, foreground and background extremes
  task automatic test_full_bytes();
    configure(255, 0, 1, 1, 0, 8);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    settle();
    configure(8'h3C, 255, 0, 0, 0, 8);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h5A);
    settle();
  endtask

  // Offset into a row's first byte, with rows that end on a byte's last bit
  task automatic test_bit_offset();
    configure(8'h11, 8'h22, 1, 1, 7, 9);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'h80);
    settle();
    configure(8'h11, 8'h22, 0, 0, 7, 9);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h81);
    settle();
  endtask

  // Zero width behaves as one; an oversized width keeps long rows open
  task automatic test_width_limits();
    configure(8'hF0, 8'h0F, 1, 1, 5, 0);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h04);
    settle();
    configure(8'h99, 8'h66, 1, 0, 3, 8191);
    send_random(WIDE_ROW_BYTES);
    settle();
  endtask

  // Width lowered below the current column, offset changed inside a row
  task automatic test_mid_row_writes();
    configure(8'h42, 8'h24, 1, 1, 0, 50);
    send_random(3);
    settle();
    write_reg(REG_ROW_WIDTH, 10);
    send_random(3);
    settle();
    configure(8'h42, 8'h24, 0, 1, 0, 20);
    send_byte(8'hC3);
    settle();
    write_reg(REG_FIRST_BIT_OFS, 5);
    send_random(3);
    settle();
  endtask

  // Writes to indexes with no register must change nothing
  task automatic test_unknown_index();
    configure(8'h5A, 8'hA5, 1, 1, 2, 11);
    write_reg(REG_SPARE_6, 13'h1FFF);
    write_reg(REG_SPARE_7, 13'h1FFF);
    send_random(3);
    settle();
  endtask

  // Receiver holds off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    configure(8'hE7, 8'h18, 1, 0, 1, 37);
    hold_left = LONG_HOLD;
    send_random(40);
    settle();
  endtask

  // Random settings and byte streams under each idling mix
  task automatic test_random_traffic();
    int          phase;
    int          sent;
    int          n;
    int unsigned width;
    int unsigned r;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 49; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 49; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 60)      width = $urandom_range(24, 1);
        else if (r < 80) width = $urandom_range(100, 25);
        else if (r < 90) width = $urandom_range(1, 0);
        else if (r < 97) width = $urandom_range(300, 101);
        else             width = $urandom_range(8191, 4090);
        configure($urandom_range(255), $urandom_range(255), $urandom_range(1),
                  $urandom_range(1), $urandom_range(7), width);
        n = $urandom_range(30, 6);
        send_random(n);
        sent += n;
        settle();
      end
    end
  endtask

  // Receiver ready: random stalls, or a counted hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare each pixel transaction with the oldest prediction
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel: pixel_value=%0h write_enable=%0b row_end=%0b last=%0b",
               out_ch.pixel_value, out_ch.write_enable, out_ch.row_end, out_ch.last);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.pixel_value !== want.pixel_value) begin
          $error("pixel_value: expected %0h, got %0h", want.pixel_value, out_ch.pixel_value);
          errors++;
        end
        if (out_ch.write_enable !== want.write_enable) begin
          $error("write_enable: expected %0b, got %0b", want.write_enable,
                 out_ch.write_enable);
          errors++;
        end
        if (out_ch.row_end !== want.row_end) begin
          $error("row_end: expected %0b, got %0b", want.row_end, out_ch.row_end);
          errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_ch.last);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Test sequence
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.glyph_bits = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_full_bytes();
    test_bit_offset();
    test_width_limits();
    test_mid_row_writes();
    test_unknown_index();
    test_backpressure();
    test_random_traffic();

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/mbe_pkg.sv
rtl/mbe_if.sv
rtl/mbe_front.sv
rtl/mbe_queue.sv
rtl/mbe_back.sv
rtl/mono_bitmap_to_8bpp_expander_top.sv
rtl/mbe_checker.sv
tb/tb.sv
